### sv/dea_pkg.sv
// ----------------------------------------------------------------------------
// dea_pkg
// shared widths and codes for the double ended array store
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dea_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned STAT_W  = 2;

  typedef logic [CMD_W-1:0]          cmd_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [POS_W-1:0]          pos_t;
  typedef logic [COUNT_W-1:0]        count_t;
  typedef logic [STAT_W-1:0]         stat_t;

  localparam cmd_t CMD_PUSH_BACK  = 3'd0;
  localparam cmd_t CMD_PUSH_FRONT = 3'd1;
  localparam cmd_t CMD_POP_BACK   = 3'd2;
  localparam cmd_t CMD_POP_FRONT  = 3'd3;
  localparam cmd_t CMD_READ       = 3'd4;

  localparam stat_t STAT_OK    = 2'd0;
  localparam stat_t STAT_EMPTY = 2'd1;
  localparam stat_t STAT_FULL  = 2'd2;
  localparam stat_t STAT_RANGE = 2'd3;

  localparam value_t VALUE_NONE  = 32'sd0;
  localparam value_t VALUE_RANGE = -32'sd1;

endpackage

`default_nettype wire

### sv/dea_if.sv
// ----------------------------------------------------------------------------
// dea channel interfaces
// valid/ready channels for commands and results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dea_req_if;
  logic            valid;
  logic            ready;
  dea_pkg::cmd_t   command;
  dea_pkg::value_t value;
  dea_pkg::pos_t   position;

  modport source (output valid, command, value, position, input ready);
  modport sink (input valid, command, value, position, output ready);
endinterface

interface dea_rsp_if;
  logic            valid;
  logic            ready;
  dea_pkg::value_t read_data;
  dea_pkg::count_t element_count;
  dea_pkg::count_t reported_capacity;
  dea_pkg::stat_t  status;

  modport source (output valid, read_data, element_count, reported_capacity, status,
                  input ready);
  modport sink (input valid, read_data, element_count, reported_capacity, status,
                output ready);
endinterface

`default_nettype wire

### sv/double_ended_array_store.sv
// ----------------------------------------------------------------------------
// double_ended_array_store
// ring-buffer deque of signed words with block-granular capacity reporting
// ----------------------------------------------------------------------------
// result: the result word is registered and valid in the cycle after the command word is taken
// throughput: one command per cycle while results are taken; each command makes at most one write
//   and one read of the element memory, whose read data is registered
// reset: empty store, front at entry 0, capacity one block; memory contents
//   are not cleared, only entries below the count are ever returned
`timescale 1ns / 1ps
`default_nettype none

module double_ended_array_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned BLOCK = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  dea_req_if.sink   req,
  dea_rsp_if.source rsp
);

  import dea_pkg::*;

  localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned CAP_W  = $clog2(DEPTH + BLOCK + 1);
  localparam int unsigned SUM_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int unsigned PH_W   = (BLOCK > 1) ? $clog2(BLOCK) : 1;
  localparam int unsigned EXT_W  = CAP_W + COUNT_W;
  localparam logic [PH_W-1:0] PH_ONE  = (BLOCK > 1) ? PH_W'(1) : PH_W'(0);
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(BLOCK - 1);

  // architectural state
  logic [PTR_W-1:0] front;
  logic [CNT_W-1:0] count;
  logic [CAP_W-1:0] cap;
  logic [PH_W-1:0]  phase;   // count modulo block

  logic [PTR_W-1:0] front_next;
  logic [CNT_W-1:0] count_next;
  logic [CAP_W-1:0] cap_next;
  logic [PH_W-1:0]  phase_next;

  // result register
  logic  out_valid;
  stat_t out_status;
  logic  out_read_ok;
  logic  out_is_read;
  stat_t status_next;
  logic  read_ok_next;
  logic  is_read_next;

  logic             accept;
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  logic [PTR_W-1:0] rd_addr;
  logic [SUM_W-1:0] back_sum;
  logic [SUM_W-1:0] pos_sum;
  logic [SUM_W-1:0] back_wrap;
  logic [SUM_W-1:0] pos_wrap;
  logic [PTR_W-1:0] front_dec;
  logic [PTR_W-1:0] front_inc;
  logic [CAP_W-1:0] count_cap;
  logic [CAP_W-1:0] count_dec_cap;
  logic [31:0]      ram_rdata;
  logic [EXT_W-1:0] count_ext;
  logic [EXT_W-1:0] cap_ext;

  assign accept    = req.valid && req.ready;
  assign req.ready = !out_valid || rsp.ready;

  // ring index arithmetic, sums stay below twice the depth where used
  assign back_sum  = SUM_W'(front) + SUM_W'(count);
  assign pos_sum   = SUM_W'(front) + SUM_W'(req.position);
  assign back_wrap = (back_sum >= SUM_W'(DEPTH)) ? back_sum - SUM_W'(DEPTH) : back_sum;
  assign pos_wrap  = (pos_sum >= SUM_W'(DEPTH)) ? pos_sum - SUM_W'(DEPTH) : pos_sum;
  assign front_dec = (front == '0) ? PTR_W'(DEPTH - 1) : front - PTR_W'(1);
  assign front_inc = (front == PTR_W'(DEPTH - 1)) ? '0 : front + PTR_W'(1);
  assign rd_addr   = pos_wrap[PTR_W-1:0];

  assign count_cap     = CAP_W'(count);
  assign count_dec_cap = CAP_W'(count) - CAP_W'(1);

  always_comb begin
    front_next   = front;
    count_next   = count;
    cap_next     = cap;
    phase_next   = phase;
    status_next  = STAT_OK;
    read_ok_next = 1'b0;
    is_read_next = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = back_wrap[PTR_W-1:0];
    unique case (req.command)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (count == CNT_W'(DEPTH)) begin
          status_next = STAT_FULL;
        end else begin
          if (count_cap >= cap) begin
            cap_next = cap + CAP_W'(BLOCK);
          end
          if (req.command == CMD_PUSH_FRONT) begin
            front_next = front_dec;
            wr_addr    = front_dec;
          end
          wr_en      = 1'b1;
          count_next = count + CNT_W'(1);
          phase_next = (phase == PH_LAST) ? '0 : phase + PH_W'(1);
        end
      end
      CMD_POP_BACK, CMD_POP_FRONT: begin
        if (count == '0) begin
          status_next = STAT_EMPTY;
        end else begin
          if (req.command == CMD_POP_FRONT) begin
            front_next = front_inc;
          end
          count_next = count - CNT_W'(1);
          phase_next = (phase == '0) ? PH_LAST : phase - PH_W'(1);
          // shrink when the new count lands on a block boundary, keeping one spare block and at least one block
          if (phase == PH_ONE && cap != count_dec_cap + CAP_W'(BLOCK) &&
              cap > CAP_W'(BLOCK)) begin
            cap_next = cap - CAP_W'(BLOCK);
          end
        end
      end
      CMD_READ: begin
        is_read_next = 1'b1;
        if (SUM_W'(req.position) < SUM_W'(count)) begin
          read_ok_next = 1'b1;
        end else begin
          status_next = STAT_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      count     <= '0;
      cap       <= CAP_W'(BLOCK);
      phase     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        front     <= front_next;
        count     <= count_next;
        cap       <= cap_next;
        phase     <= phase_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status  <= status_next;
      out_read_ok <= read_ok_next;
      out_is_read <= is_read_next;
    end
  end

  dea_ram #(
    .DEPTH (DEPTH),
    .WIDTH (VALUE_W)
  ) u_ram (
    .clk   (clk),
    .we    (accept && wr_en),
    .waddr (wr_addr),
    .wdata (req.value),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // state only moves on accept, so it always matches the word on display
  assign count_ext = EXT_W'(count);
  assign cap_ext   = EXT_W'(cap);

  assign rsp.valid             = out_valid;
  assign rsp.status            = out_status;
  assign rsp.element_count     = count_ext[COUNT_W-1:0];
  assign rsp.reported_capacity = cap_ext[COUNT_W-1:0];

  always_comb begin
    priority if (out_read_ok) begin
      rsp.read_data = ram_rdata;
    end else if (out_is_read) begin
      rsp.read_data = VALUE_RANGE;
    end else begin
      rsp.read_data = VALUE_NONE;
    end
  end

endmodule

`default_nettype wire

### sv/dea_ram.sv
// ----------------------------------------------------------------------------
// dea_ram
// element memory, one write and one read port, registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dea_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### tb/tb_double_ended_array_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_array_store
// self-checking bench for the double ended array store: a short directed
// run over empty pops, spare command codes and extreme words, then random
// fill, drain and mixed bursts under three idling patterns, each result
// checked against an in-bench model of the ring, count and capacity
// ----------------------------------------------------------------------------

module tb_double_ended_array_store;
  import dea_pkg::*;

  localparam int unsigned DEPTH           = 64;
  localparam int unsigned BLOCK           = 4;
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned ITEMS_PER_PHASE = 576;
  localparam int unsigned TAIL_CYCLES     = 8;
  localparam int unsigned RESET_CYCLES    = 5;
  localparam int unsigned REPORT_LIMIT    = 10;

  localparam cmd_t   CMD_SPARE_FIRST = CMD_READ + 3'd1;
  localparam cmd_t   CMD_SPARE_LAST  = '1;
  localparam value_t VALUE_MAX       = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam value_t VALUE_MIN       = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam value_t VALUE_MINUS_ONE = '1;

  typedef struct {
    value_t read_data;
    count_t element_count;
    count_t reported_capacity;
    stat_t  status;
  } deque_result_t;

  logic clk;
  logic rst;

  dea_req_if req ();
  dea_rsp_if rsp ();

  double_ended_array_store #(
    .DEPTH(DEPTH),
    .BLOCK(BLOCK)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // model state
  value_t store_mem [DEPTH];
  pos_t   front_idx;
  count_t elem_count;
  count_t cap_level;

  deque_result_t pending_results [$];

  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;
  int unsigned words_sent;
  int unsigned results_checked;
  int unsigned fail_count;
  int unsigned full_refusals;
  int unsigned empty_pops;
  int unsigned range_reads;
  int unsigned peak_count;
  int unsigned stall_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic deque_result_t apply_command(cmd_t cmd, value_t val, pos_t pos);
    deque_result_t r;
    r.read_data = VALUE_NONE;
    r.status    = STAT_OK;
    case (cmd)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (elem_count >= count_t'(DEPTH)) begin
          r.status = STAT_FULL;
          full_refusals++;
        end else begin
          if (elem_count >= cap_level) begin
            cap_level = cap_level + count_t'(BLOCK);
          end
          if (cmd == CMD_PUSH_BACK) begin
            store_mem[front_idx + pos_t'(elem_count)] = val;
          end else begin
            front_idx = front_idx - 1'b1;
            store_mem[front_idx] = val;
          end
          elem_count = elem_count + 1'b1;
          if (elem_count > peak_count) begin
            peak_count = elem_count;
          end
        end
      end
      CMD_POP_BACK, CMD_POP_FRONT: begin
        if (elem_count == '0) begin
          r.status = STAT_EMPTY;
          empty_pops++;
        end else begin
          if (cmd == CMD_POP_FRONT) begin
            front_idx = front_idx + 1'b1;
          end
          elem_count = elem_count - 1'b1;
          // shrink only on a block boundary, keeping one spare block
          if ((elem_count % BLOCK) == 0 && cap_level != elem_count + count_t'(BLOCK) &&
              cap_level > count_t'(BLOCK)) begin
            cap_level = cap_level - count_t'(BLOCK);
          end
        end
      end
      CMD_READ: begin
        if (count_t'(pos) < elem_count) begin
          r.read_data = store_mem[front_idx + pos];
        end else begin
          r.read_data = VALUE_RANGE;
          r.status    = STAT_RANGE;
          range_reads++;
        end
      end
      default: begin
      end
    endcase
    r.element_count     = elem_count;
    r.reported_capacity = cap_level;
    return r;
  endfunction

  function automatic value_t pick_value();
    case ($urandom_range(7))
      0: return VALUE_MAX;
      1: return VALUE_MIN;
      2: return VALUE_MINUS_ONE;
      3: return VALUE_NONE;
      default: return value_t'($urandom);
    endcase
  endfunction

  task automatic send_word(cmd_t cmd, value_t val, pos_t pos);
    deque_result_t expected;
    while ($urandom_range(99) < sender_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid    <= 1'b1;
    req.command  <= cmd;
    req.value    <= val;
    req.position <= pos;
    do @(posedge clk); while (!req.ready);
    expected = apply_command(cmd, val, pos);
    pending_results.insert(pending_results.size(), expected);
    words_sent++;
  endtask

  // hold the sender off until every outstanding result is back
  task automatic wait_for_results();
    req.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic send_random_push();
    send_word($urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_value(),
              pos_t'($urandom));
  endtask

  task automatic send_random_pop();
    send_word($urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK, value_t'($urandom),
              pos_t'($urandom));
  endtask

  task automatic send_random_read();
    pos_t pos;
    if (elem_count != '0 && $urandom_range(4) != 0) begin
      pos = pos_t'($urandom_range(elem_count - 1));
    end else begin
      pos = pos_t'($urandom);
    end
    send_word(CMD_READ, value_t'($urandom), pos);
  endtask

  task automatic test_empty_store();
    send_word(CMD_POP_BACK, value_t'($urandom), pos_t'($urandom));
    send_word(CMD_POP_FRONT, value_t'($urandom), pos_t'($urandom));
    send_word(CMD_READ, VALUE_NONE, '0);
    send_word(CMD_READ, VALUE_NONE, '1);
  endtask

  task automatic test_spare_codes();
    for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++) begin
      send_word(cmd_t'(c), value_t'($urandom), pos_t'($urandom));
    end
  endtask

  task automatic test_value_extremes();
    send_word(CMD_PUSH_BACK, VALUE_MAX, '0);
    send_word(CMD_PUSH_FRONT, VALUE_MIN, '1);
    send_word(CMD_PUSH_BACK, VALUE_MINUS_ONE, '0);
    send_word(CMD_PUSH_FRONT, VALUE_NONE, '0);
    // fifth word crosses into a second block
    send_word(CMD_PUSH_BACK, value_t'($urandom), '0);
    for (int p = 0; p <= 5; p++) begin
      send_word(CMD_READ, VALUE_NONE, pos_t'(p));
    end
    send_word(CMD_POP_FRONT, VALUE_NONE, '0);
    send_word(CMD_POP_BACK, VALUE_NONE, '0);
    send_word(CMD_POP_BACK, VALUE_NONE, '0);
    send_word(CMD_POP_FRONT, VALUE_NONE, '0);
    send_word(CMD_POP_FRONT, VALUE_NONE, '0);
  endtask

  task automatic test_random_traffic(int unsigned n_items);
    int unsigned start;
    int unsigned mode;
    int unsigned pick;
    start = words_sent;
    while (words_sent - start < n_items) begin
      mode = $urandom_range(9);
      if (mode < 2) begin
        // fill to the top, then knock on a full store
        while (elem_count < count_t'(DEPTH)) begin
          send_random_push();
        end
        repeat ($urandom_range(3)) send_random_push();
        repeat ($urandom_range(4)) send_random_read();
      end else if (mode < 4) begin
        while (elem_count != '0) begin
          if ($urandom_range(3) == 0) begin
            send_random_read();
          end else begin
            send_random_pop();
          end
        end
        repeat ($urandom_range(2)) send_random_pop();
      end else begin
        repeat ($urandom_range(40, 8)) begin
          pick = $urandom_range(99);
          if (pick < 35) begin
            send_random_push();
          end else if (pick < 62) begin
            send_random_pop();
          end else if (pick < 96) begin
            send_random_read();
          end else begin
            send_word(cmd_t'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST)),
                      value_t'($urandom), pos_t'($urandom));
          end
        end
      end
      if ($urandom_range(15) == 0) begin
        wait_for_results();
      end
    end
  endtask

  // receiver back-pressure
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    deque_result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
          $display("unexpected result word: data %0d count %0d cap %0d status %0d",
                   rsp.read_data, rsp.element_count, rsp.reported_capacity, rsp.status);
        end
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (rsp.read_data !== want.read_data || rsp.element_count !== want.element_count ||
            rsp.reported_capacity !== want.reported_capacity ||
            rsp.status !== want.status) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("result %0d mismatch: expected data %0d count %0d cap %0d status %0d",
                     results_checked, want.read_data, want.element_count,
                     want.reported_capacity, want.status);
            $display("  got data %0d count %0d cap %0d status %0d",
                     rsp.read_data, rsp.element_count, rsp.reported_capacity, rsp.status);
          end
        end
        results_checked++;
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no word accepted for %0d cycles, %0d results outstanding",
               stall_cycles, pending_results.size());
      $display("double_ended_array_store regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst          <= 1'b1;
    req.valid    <= 1'b0;
    req.command  <= CMD_PUSH_BACK;
    req.value    <= VALUE_NONE;
    req.position <= '0;
    front_idx         = '0;
    elem_count        = '0;
    cap_level         = count_t'(BLOCK);
    words_sent        = 0;
    results_checked   = 0;
    fail_count        = 0;
    full_refusals     = 0;
    empty_pops        = 0;
    range_reads       = 0;
    peak_count        = 0;
    sender_idle_pct   = 10;
    receiver_idle_pct = 87;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_empty_store();
    test_spare_codes();
    test_value_extremes();
    test_random_traffic(ITEMS_PER_PHASE);
    wait_for_results();

    sender_idle_pct   = 87;
    receiver_idle_pct = 10;
    test_random_traffic(ITEMS_PER_PHASE);
    wait_for_results();

    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    test_random_traffic(ITEMS_PER_PHASE);
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d command words and %0d result words, peak occupancy %0d of %0d",
             words_sent, results_checked, peak_count, DEPTH);
    $display("  %0d refused pushes, %0d pops on empty, %0d out-of-range reads",
             full_refusals, empty_pops, range_reads);
    if (fail_count == 0) begin
      $display("double_ended_array_store regression: pass");
    end else begin
      $display("double_ended_array_store regression: fail");
    end
    $finish;
  end

endmodule
